// ===== hw/rtl/random_unset_bit_claimer_assert.svh =====
`ifndef RANDOM_UNSET_BIT_CLAIMER_ASSERT_SVH
`define RANDOM_UNSET_BIT_CLAIMER_ASSERT_SVH

// Assertion checked on every rising clock edge outside reset.
`define RUBC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is also checked while reset is applied.
`define RUBC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/rubc_pkg.sv =====
package rubc_pkg;

    // Fixed field widths.
    localparam int RND_W   = 16;
    localparam int IDX_W   = 5;
    localparam int SLOT_W  = 6;
    localparam int MAP_MAX = 32;

    // Operation codes.
    localparam logic OP_CLAIM = 1'b0;
    localparam logic OP_TEST  = 1'b1;

    // Input transaction.
    typedef struct packed {
        logic             operation;
        logic [RND_W-1:0] random_value;
        logic [IDX_W-1:0] slot_index;
    } t_in;

    // Output transaction.
    typedef struct packed {
        logic [SLOT_W-1:0] chosen_slot;
        logic              slot_claimed;
        logic              all_claimed;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_step;
        logic scan_step;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic claim;
        logic pool_full;
        logic div_last;
        logic scan_hit;
    } t_status;

endpackage

// ===== hw/rtl/random_unset_bit_claimer.sv =====
// Channel   Handshake            Payload
// input     i_valid / o_ready    i_in  (operation, random_value, slot_index)
// output    o_valid / i_ready    o_out (chosen_slot, slot_claimed, all_claimed)
//
// A test, or a claim on a full pool, skips the modulo and the scan and goes from setup to the output register.
// A claim that finds slot j goes through setup, then a bit-serial modulo over the sixteen bits
// of random_value, then a scan of one slot per cycle up to slot j.
// A new transaction is accepted once the previous one has reached the output register.
// Synchronous active-low reset clears the slot map, sets the free count to POOL_SIZE and clears all control.
// A stalled output holds its transaction; the next result waits until it is taken.
module random_unset_bit_claimer #(
    parameter int POOL_SIZE = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rubc_pkg::t_in  i_in,
    output logic           o_valid,
    input  logic           i_ready,
    output rubc_pkg::t_out o_out
);
    import rubc_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequencer.
    rubc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Slot map, divider and scanner.
    rubc_datapath #(
        .POOL_SIZE (POOL_SIZE)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cmd    (cmd),
        .o_status (status),
        .o_out    (o_out)
    );

endmodule

// ===== hw/rtl/rubc_datapath.sv =====
module rubc_datapath #(
    parameter int POOL_SIZE = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rubc_pkg::t_in    i_in,
    input  rubc_pkg::t_cmd   i_cmd,
    output rubc_pkg::t_status o_status,
    output rubc_pkg::t_out   o_out
);
    import rubc_pkg::*;

    localparam int CW  = $clog2(POOL_SIZE + 1);
    localparam int IW  = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int DCW = $clog2(RND_W);

    logic [POOL_SIZE-1:0] r_map;
    logic [CW-1:0]        r_free;
    logic                 r_op;
    logic [RND_W-1:0]     r_rnd;
    logic [IDX_W-1:0]     r_idx;
    logic [CW-1:0]        r_rem;
    logic [DCW-1:0]       r_cnt;
    logic [IW-1:0]        r_pos;
    logic [SLOT_W-1:0]    r_chosen;
    t_out                 r_out;

    logic [CW:0]          rem_sh;
    logic                 rem_ge;
    logic [MAP_MAX-1:0]   map_ext;
    logic                 pos_free;

    // One restoring division step: shift in the next dividend bit and subtract.
    assign rem_sh = {r_rem, r_rnd[RND_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_free});

    assign map_ext  = MAP_MAX'(r_map);
    assign pos_free = !r_map[r_pos];

    // Status towards the controller.
    assign o_status.claim     = (r_op == OP_CLAIM);
    assign o_status.pool_full = (r_free == '0);
    assign o_status.div_last  = (r_cnt == DCW'(RND_W - 1));
    assign o_status.scan_hit  = pos_free && (r_rem == '0);

    assign o_out = r_out;

    // Slot map and free count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map  <= '0;
            r_free <= CW'(POOL_SIZE);
        end else if (i_cmd.scan_step && pos_free && (r_rem == '0)) begin
            r_map[r_pos] <= 1'b1;
            r_free       <= r_free - 1'b1;
        end
    end

    // Working registers for the current transaction.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_in.operation;
            r_rnd    <= i_in.random_value;
            r_idx    <= i_in.slot_index;
            r_rem    <= '0;
            r_cnt    <= '0;
            r_pos    <= '0;
            r_chosen <= SLOT_W'(POOL_SIZE);
        end else if (i_cmd.div_step) begin
            r_rnd <= {r_rnd[RND_W-2:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
            if (rem_ge) begin
                r_rem <= CW'(rem_sh - {1'b0, r_free});
            end else begin
                r_rem <= CW'(rem_sh);
            end
        end else if (i_cmd.scan_step) begin
            // Walk upward; each free slot passed uses up one step of the remainder.
            r_pos <= r_pos + 1'b1;
            if (pos_free) begin
                if (r_rem == '0) begin
                    r_chosen <= SLOT_W'(r_pos);
                end else begin
                    r_rem <= r_rem - 1'b1;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.chosen_slot  <= r_chosen;
            r_out.slot_claimed <= (r_op == OP_TEST) && map_ext[r_idx];
            r_out.all_claimed  <= (r_free == '0);
        end
    end

endmodule

// ===== hw/rtl/rubc_ctrl.sv =====
module rubc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    input  rubc_pkg::t_status i_status,
    output rubc_pkg::t_cmd    o_cmd
);
    import rubc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_DIV,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   n_valid;
    logic   out_free;

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_valid;
    assign out_free = !r_valid || i_ready;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_valid = r_valid && !i_ready;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SETUP;
                end
            end
            S_SETUP: begin
                if (i_status.claim && !i_status.pool_full) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_hit) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Wait until the output register is empty or being emptied.
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_valid        = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

endmodule

// ===== hw/rtl/rubc_checker.sv =====
`include "random_unset_bit_claimer_assert.svh"

module rubc_checker #(
    parameter int POOL_SIZE = 32
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_ready,
    input rubc_pkg::t_in  i_in,
    input logic           o_valid,
    input logic           i_ready,
    input rubc_pkg::t_out o_out
);
    import rubc_pkg::*;

    // No result is offered straight after reset.
    `RUBC_ASSERT_ALWAYS(a_rst_no_valid, i_clk, !i_rst_n |=> !o_valid, "valid after reset")

    // One transaction at a time: acceptance closes the input until the work is done.
    `RUBC_ASSERT(a_one_at_a_time, i_clk, i_rst_n, (i_valid && o_ready) |=> !o_ready, "overlap")

    // A tested slot never reports a claimed slot index.
    `RUBC_ASSERT(a_test_no_slot, i_clk, i_rst_n, (o_valid && o_out.slot_claimed) |-> (o_out.chosen_slot == SLOT_W'(POOL_SIZE)), "test with slot")

    // A stalled result is held.
    `RUBC_ASSERT(a_out_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> (o_valid && $stable(o_out)), "result dropped")

endmodule

bind random_unset_bit_claimer rubc_checker #(
    .POOL_SIZE (POOL_SIZE)
) u_rubc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_in    (i_in),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_out   (o_out)
);
